>>> sv/fpfa_pkg.sv
// Shared types, widths and codes for the fixed-partition fit allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int SIZE_BITS   = 16;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int BIDX_W   = 4;
   localparam int AMT_W    = 16;
   localparam int STATUS_W = 2;
   localparam int CHOSEN_W = 4;
   localparam int SUM_W    = 20;
   localparam int MODE_W   = 2;
   localparam int BCNT_W   = 5;

   // compare width covers both stored sizes and requests
   localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;
   localparam int SAT_W = ((CMP_W > SUM_W) ? CMP_W : SUM_W) + 1;

   localparam logic [SUM_W-1:0]  SUM_MAX         = '1;
   localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = BCNT_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_DONE      = 2'd0,
      RSP_ALLOCATED = 2'd1,
      RSP_NO_FIT    = 2'd2
   } status_type;

   // scan unit -> top
   typedef struct packed {
      logic                 done;
      logic                 hit;
      logic [IDX_W-1:0]     index;
      logic [SIZE_BITS-1:0] size;
   } scan_result_type;

   // top -> block store
   typedef struct packed {
      logic                 size_we;
      logic [IDX_W-1:0]     size_idx;
      logic [SIZE_BITS-1:0] size_data;
      logic                 set_used;
      logic [IDX_W-1:0]     used_idx;
      logic                 clear_used;
   } store_update_type;

endpackage

`default_nettype wire

>>> sv/fixed_partition_fit_allocator_top.sv
// Top level of the fixed-partition fit allocator: CSR port, command sequencer,
// result register. Depends on fpfa_pkg, fpfa_store and fpfa_scan.
//
// Usage
//  - req channel (valid/stall) carries one command beat: load a block size,
//    allocate a request, or clear all allocations. Every beat gives exactly one
//    rsp beat with status, granted block, leftover and running leftover total.
//  - Registers fit_mode (0 first, 1 best, 2 worst; 3 acts as first fit) and
//    block_count (saturates at the table depth) sit on the APB port at byte
//    addresses 0 and 4. Write them only while the block is idle.
//  - Sequence: a load or clear goes from acceptance to the done state and
//    then into the result register; an allocate first runs its scan. The
//    walk goes through one compare unit, one table entry a cycle, and stops
//    at the first hit in first-fit mode, otherwise after all block_count
//    entries. With block_count zero an allocate never fits.
//  - Flow: one beat at a time; req_stall is high from acceptance until
//    the result is loaded into the output register.
//  - rsp stall: the result register holds its beat; a new request may still be
//    accepted and works through its scan, then waits in the commit cycle
//    until the register frees. State is updated only at that commit.
//  - Reset (synchronous, active high): all blocks free, sizes read as zero,
//    total zero, fit_mode 0, block_count 16, no beat pending.
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_fit_allocator_top import fpfa_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [CMD_W-1:0]    req_cmd,
   input  wire logic [BIDX_W-1:0]   req_block_index,
   input  wire logic [AMT_W-1:0]    req_amount,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [CHOSEN_W-1:0] rsp_chosen_block,
   output logic      [AMT_W-1:0]    rsp_leftover,
   output logic      [SUM_W-1:0]    rsp_total_leftover,
   // register port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic      [31:0]         prdata,
   output logic                     pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // register select is the word address bit
   localparam logic REG_FIT_MODE    = 1'b0;
   localparam logic REG_BLOCK_COUNT = 1'b1;

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [BIDX_W-1:0]   idx_ff;
   logic [AMT_W-1:0]    amount_ff;
   logic [MODE_W-1:0]   fit_mode_ff, fit_mode_in;
   logic [BCNT_W-1:0]   block_count_ff, block_count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CHOSEN_W-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic [AMT_W-1:0]    rsp_left_ff, rsp_left_in;

   logic                accept;
   logic                out_free;
   logic                commit;
   logic                csr_write;
   logic [CNT_W-1:0]    count_n;
   logic [CMP_W-1:0]    diff;
   logic [SAT_W-1:0]    room;
   logic [SUM_W-1:0]    sum_added;
   logic [IDX_W-1:0]    scan_ptr;
   logic [SIZE_BITS-1:0] rd_size;
   logic                rd_used;
   scan_result_type     scan_res;
   store_update_type    upd;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_DONE) && out_free;

   // ---- register port ----
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_FIT_MODE:    fit_mode_in    = pwdata[MODE_W-1:0];
            REG_BLOCK_COUNT: block_count_in = pwdata[BCNT_W-1:0];
            default:         fit_mode_in    = fit_mode_ff;
         endcase
      end
      unique case (paddr[2])
         REG_FIT_MODE:    prdata = {{(32-MODE_W){1'b0}}, fit_mode_ff};
         REG_BLOCK_COUNT: prdata = {{(32-BCNT_W){1'b0}}, block_count_ff};
         default:         prdata = '0;
      endcase
   end

   // active entries: count above the table depth saturates
   assign count_n = (int'(block_count_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(block_count_ff);

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_cmd == CMD_ALLOC) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_res.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- commit: table update, saturating total, result beat ----
   always_comb begin
      diff      = CMP_W'(scan_res.size) - CMP_W'(amount_ff);
      room      = SAT_W'(SUM_MAX) - SAT_W'(sum_ff);
      sum_added = (SAT_W'(diff) >= room) ? SUM_MAX : (sum_ff + SUM_W'(diff));

      upd            = '0;
      upd.size_idx   = IDX_W'(idx_ff);
      upd.size_data  = SIZE_BITS'(amount_ff);
      upd.used_idx   = scan_res.index;

      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_left_in   = rsp_left_ff;

      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = RSP_DONE;
         rsp_chosen_in = '0;
         rsp_left_in   = '0;
         if (cmd_ff == CMD_LOAD) begin
            // out-of-table index is answered but ignored
            upd.size_we = (int'(idx_ff) < TABLE_DEPTH);
         end else if (cmd_ff == CMD_ALLOC) begin
            if (scan_res.hit) begin
               upd.set_used  = 1'b1;
               sum_in        = sum_added;
               rsp_status_in = RSP_ALLOCATED;
               rsp_chosen_in = CHOSEN_W'(scan_res.index);
               rsp_left_in   = AMT_W'(diff);
            end else begin
               rsp_status_in = RSP_NO_FIT;
            end
         end else if (cmd_ff == CMD_CLEAR) begin
            upd.clear_used = 1'b1;
            sum_in         = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fit_mode_ff    <= MODE_W'(FIT_FIRST);
         block_count_ff <= BLOCK_COUNT_RST;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
         sum_ff         <= sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         idx_ff    <= req_block_index;
         amount_ff <= req_amount;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_left_ff   <= rsp_left_in;
      if (commit) begin
         rsp_total_leftover <= sum_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_leftover     = rsp_left_ff;

   // ---- sub-blocks ----
   fpfa_store u_store (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .rd_ptr  (scan_ptr),
      .rd_size (rd_size),
      .rd_used (rd_used)
   );

   fpfa_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && (req_cmd == CMD_ALLOC)),
      .fit_mode (fit_mode_ff),
      .count_n  (count_n),
      .request  (amount_ff),
      .rd_size  (rd_size),
      .rd_used  (rd_used),
      .rd_ptr   (scan_ptr),
      .result   (scan_res)
   );

`ifndef SYNTHESIS
   a_alloc_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_ALLOC)) |=> (state_ff == ST_SCAN))
      else $error("allocate beat did not start a scan");

   a_miss_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != RSP_ALLOCATED))
         |-> ((rsp_chosen_ff == '0) && (rsp_left_ff == '0)))
      else $error("non-grant result carries block or leftover");

   a_clear_zeroes_total: assert property (@(posedge clock) disable iff (reset)
      (commit && (cmd_ff == CMD_CLEAR)) |=> (sum_ff == '0))
      else $error("clear left a non-zero leftover total");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      (commit && (cmd_ff == CMD_ALLOC)) |=> (sum_ff >= $past(sum_ff)))
      else $error("leftover total fell on an allocate");
`endif

endmodule

`default_nettype wire

>>> sv/fpfa_store.sv
// Block size table and used flags, one read port at the scan pointer.
// Depends on fpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpfa_store import fpfa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire store_update_type     upd,
   input  wire logic [IDX_W-1:0]     rd_ptr,
   output logic      [SIZE_BITS-1:0] rd_size,
   output logic                      rd_used
);

   logic [SIZE_BITS-1:0]   size_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] valid_in;
   logic [TABLE_DEPTH-1:0] used_ff;
   logic [TABLE_DEPTH-1:0] used_in;

   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      if (upd.size_we) begin
         valid_in[upd.size_idx] = 1'b1;
      end
      if (upd.clear_used) begin
         used_in = '0;
      end else if (upd.set_used) begin
         used_in[upd.used_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
      end
   end

   // sizes carry no reset; an unwritten entry reads as zero via valid_ff
   always_ff @(posedge clock) begin
      if (upd.size_we) begin
         size_ff[upd.size_idx] <= upd.size_data;
      end
   end

   always_comb begin
      rd_size = valid_ff[rd_ptr] ? size_ff[rd_ptr] : '0;
      rd_used = used_ff[rd_ptr];
   end

endmodule

`default_nettype wire

>>> sv/fpfa_scan.sv
// Scan sequencer: walks the table one entry a cycle through a shared compare unit.
// Depends on fpfa_pkg; reads entries from fpfa_store.
`timescale 1ns / 1ps
`default_nettype none

module fpfa_scan import fpfa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MODE_W-1:0]    fit_mode,
   input  wire logic [CNT_W-1:0]     count_n,
   input  wire logic [AMT_W-1:0]     request,
   input  wire logic [SIZE_BITS-1:0] rd_size,
   input  wire logic                 rd_used,
   output logic      [IDX_W-1:0]     rd_ptr,
   output scan_result_type           result
);

   typedef enum logic [1:0] {
      SC_IDLE = 2'b01,
      SC_RUN  = 2'b10
   } scan_state_type;

   scan_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic                 have_ff, have_in;
   logic                 done_ff, done_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;

   logic [CMP_W-1:0] req_w;
   logic [CMP_W-1:0] cur_w;
   logic [CMP_W-1:0] best_w;
   logic             is_best;
   logic             is_worst;
   logic             fits;
   logic             bigger;
   logic             smaller;
   logic             take;
   logic             first_hit;
   logic             last;

   // shared compare unit
   always_comb begin
      req_w     = CMP_W'(request);
      cur_w     = CMP_W'(rd_size);
      best_w    = CMP_W'(best_size_ff);
      is_best   = (fit_mode == FIT_BEST);
      is_worst  = (fit_mode == FIT_WORST);
      fits      = (cur_w >= req_w);
      bigger    = !have_ff || (cur_w > best_w);
      smaller   = !have_ff || (cur_w < best_w);
      if (rd_used) begin
         take = 1'b0;
      end else if (is_worst) begin
         take = bigger;
      end else if (is_best) begin
         take = fits && smaller;
      end else begin
         take = fits;
      end
      first_hit = take && !is_best && !is_worst;
      last      = (CNT_W'(ptr_ff) == (count_n - CNT_W'(1)));
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      have_in      = have_ff;
      done_in      = 1'b0;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               ptr_in  = '0;
               have_in = 1'b0;
               if (count_n == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = SC_RUN;
               end
            end
         end
         SC_RUN: begin
            if (take) begin
               have_in      = 1'b1;
               best_idx_in  = ptr_ff;
               best_size_in = rd_size;
            end
            if (first_hit || last) begin
               state_in = SC_IDLE;
               done_in  = 1'b1;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         ptr_ff   <= '0;
         have_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         have_ff  <= have_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
   end

   assign rd_ptr = ptr_ff;

   // worst fit decides on the largest block only once the walk is over
   always_comb begin
      result.done  = done_ff;
      result.hit   = have_ff && (!is_worst || (best_w >= req_w));
      result.index = best_idx_ff;
      result.size  = best_size_ff;
   end

`ifndef SYNTHESIS
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_RUN) |-> (CNT_W'(ptr_ff) < count_n))
      else $error("scan pointer beyond active block count");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("scan done held for more than one cycle");

   a_start_moves: assert property (@(posedge clock) disable iff (reset)
      (start && (state_ff == SC_IDLE)) |=> ((state_ff == SC_RUN) || done_ff))
      else $error("scan start neither ran nor finished");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for fixed_partition_fit_allocator_top: directed table, then random phases.
// Depends on fpfa_pkg and the allocator RTL; the expected beats come from an in-bench predictor.
`timescale 1ns / 1ps

module tb;
   import fpfa_pkg::*;

   // register indexes, byte address is 4 * index
   localparam int REG_FIT_MODE    = 0;
   localparam int REG_BLOCK_COUNT = 1;

   // codes outside the package enums
   localparam logic [CMD_W-1:0]  CMD_UNKNOWN = 2'd3;
   localparam logic [MODE_W-1:0] FIT_ODD     = 2'd3;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int RAND_PHASES  = 19;
   localparam int MIXED_ITEMS  = 40;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CHOSEN_W-1:0] chosen;
      logic [AMT_W-1:0]    leftover;
      logic [SUM_W-1:0]    total;
   } grant_beat_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one line of the directed table; for ROW_CSR, block_index holds the
   // register index and amount the value
   typedef struct packed {
      row_kind_type        kind;
      logic [CMD_W-1:0]    cmd;
      logic [BIDX_W-1:0]   block_index;
      logic [AMT_W-1:0]    amount;
      logic                fixed;
      grant_beat_type      beat;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd;
   logic [BIDX_W-1:0]   req_block_index;
   logic [AMT_W-1:0]    req_amount;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [CHOSEN_W-1:0] rsp_chosen_block;
   logic [AMT_W-1:0]    rsp_leftover;
   logic [SUM_W-1:0]    rsp_total_leftover;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [2:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   fixed_partition_fit_allocator_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_block_index    (req_block_index),
      .req_amount         (req_amount),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_chosen_block   (rsp_chosen_block),
      .rsp_leftover       (rsp_leftover),
      .rsp_total_leftover (rsp_total_leftover),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // --------------------------------------------------------------------
   // Predictor state: own copy of the table, the used flags, the running
   // leftover total and both registers, all at their reset values.
   // --------------------------------------------------------------------
   logic [SIZE_BITS-1:0]   tbl_size [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] tbl_used = '0;
   logic [SUM_W-1:0]       tbl_sum  = '0;
   logic [MODE_W-1:0]      cfg_mode  = FIT_FIRST;
   logic [BCNT_W-1:0]      cfg_count = BLOCK_COUNT_RST;

   grant_beat_type expected_grants [$];
   stim_row_type   directed_rows [$];

   int fault_count  = 0;
   int cycle_count  = 0;
   int send_gap_max = 0;   // sender idle cycles before each beat, 0..this
   int rsp_hold_max = 0;   // receiver stall cycles before each beat, 0..this
   bit hold_off_req = 1'b0;

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Works out the beat one command gives and moves the predictor state on.
   // Ties go to the lowest index in every mode; mode 3 walks as first fit.
   function automatic grant_beat_type predict_grant(logic [CMD_W-1:0] cmd,
                                                    logic [BIDX_W-1:0] idx,
                                                    logic [AMT_W-1:0] amt);
      grant_beat_type   g;
      int               n;
      int               i;
      int               pick;
      bit               found;
      logic [AMT_W-1:0] diff;
      logic [SUM_W:0]   acc;
      g     = '0;
      pick  = -1;
      found = 1'b0;
      g.status = RSP_DONE;
      if (cmd == CMD_LOAD) begin
         tbl_size[idx] = amt;
      end else if (cmd == CMD_ALLOC) begin
         n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
         for (i = 0; i < n; i++) begin
            if (!found && !tbl_used[i]) begin
               if (cfg_mode == FIT_WORST) begin
                  if (pick < 0 || tbl_size[i] > tbl_size[pick]) pick = i;
               end else if (tbl_size[i] >= amt) begin
                  if (cfg_mode == FIT_BEST) begin
                     if (pick < 0 || tbl_size[i] < tbl_size[pick]) pick = i;
                  end else begin
                     pick  = i;
                     found = 1'b1;
                  end
               end
            end
         end
         // worst fit picks the largest first, then checks that it fits
         if (cfg_mode == FIT_WORST && pick >= 0 && tbl_size[pick] < amt) pick = -1;
         if (pick < 0) begin
            g.status = RSP_NO_FIT;
         end else begin
            diff           = tbl_size[pick] - amt;
            tbl_used[pick] = 1'b1;
            g.status       = RSP_ALLOCATED;
            g.chosen       = pick[CHOSEN_W-1:0];
            g.leftover     = diff;
            acc            = tbl_sum + diff;
            tbl_sum        = (acc >= SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
         end
      end else if (cmd == CMD_CLEAR) begin
         tbl_used = '0;
         tbl_sum  = '0;
      end
      g.total = tbl_sum;
      return g;
   endfunction

   task automatic note_fault(string msg);
      if (fault_count < 10) $display("%0t: %s", $realtime, msg);
      fault_count++;
   endtask

   // --------------------------------------------------------------------
   // Result side: draws a stall count per beat, checks every accepted beat
   // against the oldest expectation. A long hold-off can be asked for by
   // the stimulus; it is counted out here.
   // --------------------------------------------------------------------
   initial begin
      int             hold;
      grant_beat_type want;
      grant_beat_type got;
      hold      = 0;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            got = '{rsp_status, rsp_chosen_block, rsp_leftover, rsp_total_leftover};
            if (expected_grants.size() == 0) begin
               note_fault($sformatf("unexpected beat %h", got));
            end else begin
               want = expected_grants.pop_front();
               if (got.status !== want.status || got.chosen !== want.chosen ||
                   got.leftover !== want.leftover || got.total !== want.total)
                  note_fault($sformatf(
                     "beat mismatch: status %0d/%0d block %0d/%0d left %0d/%0d total %0d/%0d",
                     want.status, got.status, want.chosen, got.chosen,
                     want.leftover, got.leftover, want.total, got.total));
            end
            hold = $urandom_range(0, rsp_hold_max);
         end
         @(negedge clock);
         if (hold_off_req) begin
            hold         = LONG_HOLD;
            hold_off_req = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------
   // Request side. Tasks start and end just after a falling edge. valid is
   // left high after a beat so back-to-back beats need no second write.
   // --------------------------------------------------------------------
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                            logic [AMT_W-1:0] amt, bit fixed,
                            grant_beat_type fixed_beat);
      int             gap;
      grant_beat_type g;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_block_index <= idx;
      req_amount      <= amt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // state moves in acceptance order, so predict here
      g = predict_grant(cmd, idx, amt);
      expected_grants.push_back(fixed ? fixed_beat : g);
      @(negedge clock);
   endtask

   // drop valid and let every outstanding beat come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(int reg_idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * reg_idx);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_idx == REG_FIT_MODE) cfg_mode = value[MODE_W-1:0];
      else cfg_count = value[BCNT_W-1:0];
   endtask

   task automatic add_item(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                           logic [AMT_W-1:0] amt, bit fixed, logic [STATUS_W-1:0] st);
      stim_row_type r;
      r             = '0;
      r.kind        = ROW_ITEM;
      r.cmd         = cmd;
      r.block_index = idx;
      r.amount      = amt;
      r.fixed       = fixed;
      r.beat.status = st;   // typed rows all carry zero block, leftover and total
      directed_rows.push_back(r);
   endtask

   task automatic add_csr(int reg_idx, logic [AMT_W-1:0] value);
      stim_row_type r;
      r             = '0;
      r.kind        = ROW_CSR;
      r.block_index = reg_idx[BIDX_W-1:0];
      r.amount      = value;
      directed_rows.push_back(r);
   endtask

   function automatic logic [AMT_W-1:0] draw_size();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return '0;
         1: return '1;
         2, 3, 4: return AMT_W'($urandom_range(0, 255));
         5, 6: return AMT_W'(16 << $urandom_range(0, 3));   // repeated sizes, so ties
         default: return AMT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // requests aimed at the loaded sizes: exact fits, one past, extremes
   function automatic logic [AMT_W-1:0] draw_request();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return tbl_size[$urandom_range(0, TABLE_DEPTH - 1)];
         1: return tbl_size[$urandom_range(0, TABLE_DEPTH - 1)] + 1'b1;
         2: return '0;
         3: return '1;
         4, 5, 6: return AMT_W'($urandom_range(0, 300));
         default: return AMT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [BCNT_W-1:0] draw_count();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return '0;
         1: return BCNT_W'(1);
         2: return BCNT_W'($urandom_range(2, 15));
         3: return BCNT_W'($urandom_range(17, 31));
         default: return BCNT_W'(TABLE_DEPTH);
      endcase
   endfunction

   // --------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------
   initial begin
      stim_row_type     row;
      int               ph;
      int               k;
      int               r;
      int               style;
      logic [CMD_W-1:0] cmd;
      for (k = 0; k < TABLE_DEPTH; k++) tbl_size[k] = '0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_LOAD;
      req_block_index = '0;
      req_amount      = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table: reset state, extremes, every command and mode, the
      // count limits and the odd codes
      add_item(CMD_ALLOC, 4'd0, 16'd0, 1, RSP_ALLOCATED);   // zero-size block 0 fits a zero request
      add_item(CMD_CLEAR, 4'd0, 16'd0, 1, RSP_DONE);
      add_item(CMD_LOAD, 4'd0, 16'hFFFF, 1, RSP_DONE);
      add_item(CMD_LOAD, 4'd15, 16'd100, 1, RSP_DONE);
      add_item(CMD_LOAD, 4'd1, 16'd300, 0, RSP_DONE);
      add_item(CMD_LOAD, 4'd2, 16'd50, 0, RSP_DONE);
      add_item(CMD_LOAD, 4'd3, 16'd200, 0, RSP_DONE);
      add_item(CMD_ALLOC, 4'd7, 16'hFFFF, 1, RSP_ALLOCATED); // exact fit of block 0
      add_item(CMD_ALLOC, 4'd0, 16'd60, 0, RSP_DONE);
      add_csr(REG_FIT_MODE, FIT_BEST);
      add_item(CMD_ALLOC, 4'd0, 16'd40, 0, RSP_DONE);
      add_csr(REG_FIT_MODE, FIT_WORST);
      add_item(CMD_ALLOC, 4'd0, 16'd150, 0, RSP_DONE);
      add_item(CMD_ALLOC, 4'd0, 16'd150, 0, RSP_DONE);      // largest left is too small
      add_item(CMD_LOAD, 4'd1, 16'd5, 0, RSP_DONE);         // resize a used block
      add_item(CMD_UNKNOWN, 4'd15, 16'hFFFF, 0, RSP_DONE);
      add_csr(REG_FIT_MODE, FIT_ODD);
      add_item(CMD_ALLOC, 4'd0, 16'd0, 0, RSP_DONE);
      add_item(CMD_CLEAR, 4'd15, 16'hFFFF, 1, RSP_DONE);
      add_csr(REG_BLOCK_COUNT, 16'd0);
      add_item(CMD_ALLOC, 4'd0, 16'd0, 1, RSP_NO_FIT);      // empty table never fits
      add_csr(REG_BLOCK_COUNT, 16'd1);
      add_item(CMD_ALLOC, 4'd0, 16'd1, 0, RSP_DONE);
      add_item(CMD_ALLOC, 4'd0, 16'd0, 0, RSP_DONE);
      add_csr(REG_BLOCK_COUNT, 16'd31);                     // saturates at the table depth
      add_item(CMD_ALLOC, 4'd0, 16'hFFFF, 0, RSP_DONE);
      add_item(CMD_LOAD, 4'd14, 16'hFFFF, 0, RSP_DONE);
      add_item(CMD_ALLOC, 4'd0, 16'hFFFF, 0, RSP_DONE);
      add_csr(REG_BLOCK_COUNT, 16'd16);
      add_csr(REG_FIT_MODE, FIT_FIRST);
      add_item(CMD_CLEAR, 4'd0, 16'd0, 1, RSP_DONE);

      send_gap_max = 3;
      rsp_hold_max = 3;
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            csr_write(int'(row.block_index), 32'(row.amount));
         end else begin
            send_item(row.cmd, row.block_index, row.amount, row.fixed, row.beat);
         end
      end

      // random phases: new registers, clear, load the whole table, then a
      // mix weighted towards allocation with the odd clear to free blocks
      for (ph = 0; ph < RAND_PHASES; ph++) begin
         wait_idle();
         csr_write(REG_FIT_MODE, 32'($urandom_range(0, 3)));
         csr_write(REG_BLOCK_COUNT, 32'(draw_count()));
         style        = (ph < 4) ? ph : $urandom_range(0, 3);
         send_gap_max = style[0] ? 11 : 0;
         rsp_hold_max = style[1] ? 11 : 0;
         // receiver goes quiet for a long while so the block backs up
         if (ph == 2) hold_off_req = 1'b1;
         send_item(CMD_CLEAR, BIDX_W'($urandom), AMT_W'($urandom), 0, '0);
         for (k = 0; k < TABLE_DEPTH; k++)
            send_item(CMD_LOAD, BIDX_W'(k), draw_size(), 0, '0);
         for (k = 0; k < MIXED_ITEMS; k++) begin
            r = $urandom_range(0, 19);
            if (r < 13) begin
               send_item(CMD_ALLOC, BIDX_W'($urandom), draw_request(), 0, '0);
            end else if (r < 17) begin
               send_item(CMD_LOAD, BIDX_W'($urandom), draw_size(), 0, '0);
            end else begin
               cmd = (r == 19) ? CMD_UNKNOWN : CMD_CLEAR;
               send_item(cmd, BIDX_W'($urandom), AMT_W'($urandom), 0, '0);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
